// ===== rtl/core/pdds_pkg.sv =====
// Shared types and constants for the per-destination drain scheduler.
// Used by pdds_ctrl, pdds_dp and the top level under rtl/core; depends on nothing.
package pdds_pkg;

	localparam int MAX_NODES       = 16;
	localparam int NODE_W          = 4;
	localparam int CNT_W           = 5;
	localparam int PKT_W           = 32;
	localparam int TIME_W          = 32;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int CFG_IDX_W       = 4;
	localparam int CFG_DATA_W      = 5;
	localparam int SHORT_DIV_STEPS = 5;

	localparam logic [CFG_IDX_W-1:0]  CFG_NODES  = 4'd0;
	localparam logic [CFG_IDX_W-1:0]  CFG_OWN_ID = 4'd1;
	localparam logic [CFG_DATA_W-1:0] NODES_RST  = 5'd16;

	typedef struct packed {
		logic              mode;
		logic [NODE_W-1:0] destination;
		logic [PKT_W-1:0]  packet_data;
		logic [TIME_W-1:0] tick_time;
	} in_item_t;

	typedef struct packed {
		logic              sent_valid;
		logic [NODE_W-1:0] sent_destination;
		logic [PKT_W-1:0]  sent_data;
		logic              dropped;
		logic [31:0]       total_sent;
	} out_item_t;

	typedef enum logic [1:0] {
		DIV_SLOT = 2'd0,
		DIV_PICK = 2'd1,
		DIV_WALK = 2'd2
	} div_src_t;

	typedef enum logic [9:0] {
		S_IDLE     = 10'b0000000001,
		S_ENQ      = 10'b0000000010,
		S_DIV_SLOT = 10'b0000000100,
		S_PICK     = 10'b0000001000,
		S_DIV_PICK = 10'b0000010000,
		S_POP      = 10'b0000100000,
		S_RD       = 10'b0001000000,
		S_DIV_WALK = 10'b0010000000,
		S_WALK     = 10'b0100000000,
		S_OUT      = 10'b1000000000
	} state_t;

	typedef struct packed {
		logic     load;
		logic     enq;
		logic     div_start;
		div_src_t div_src;
		logic     take_slot;
		logic     pick_list;
		logic     pick_slot;
		logic     pop;
		logic     capture;
		logic     walk_init;
		logic     walk_step;
		logic     emit;
	} ctl_cmd_t;

	typedef struct packed {
		logic item_tick;
		logic div_done;
		logic served_lt_total;
		logic total_nz;
		logic last_slot;
		logic walk_done;
		logic out_free;
	} ctl_stat_t;

endpackage

// ===== rtl/core/pdds_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module pdds_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== rtl/core/pdds_ctrl.sv =====
// Sequencer for the drain scheduler: steps enqueue and tick requests.
// Depends on pdds_pkg; drives the datapath through ctl_cmd_t.
module pdds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  pdds_pkg::ctl_stat_t stat,
	output pdds_pkg::ctl_cmd_t  cmd
);
	import pdds_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign item_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					if (stat.item_tick) begin
						cmd.div_start = 1'b1;
						cmd.div_src   = DIV_SLOT;
						state_d       = S_DIV_SLOT;
					end else begin
						state_d = S_ENQ;
					end
				end
			end
			S_ENQ: begin
				cmd.enq = 1'b1;
				state_d = S_OUT;
			end
			S_DIV_SLOT: begin
				if (stat.div_done) begin
					cmd.take_slot = 1'b1;
					state_d       = S_PICK;
				end
			end
			S_PICK: begin
				// serve each listed target once before the slot pick
				if (stat.served_lt_total) begin
					cmd.pick_list = 1'b1;
					state_d       = S_POP;
				end else if (stat.total_nz) begin
					cmd.div_start = 1'b1;
					cmd.div_src   = DIV_PICK;
					state_d       = S_DIV_PICK;
				end else begin
					state_d = S_POP;
				end
			end
			S_DIV_PICK: begin
				if (stat.div_done) begin
					cmd.pick_slot = 1'b1;
					state_d       = S_POP;
				end
			end
			S_POP: begin
				cmd.pop = 1'b1;
				state_d = S_RD;
			end
			S_RD: begin
				cmd.capture = 1'b1;
				if (stat.last_slot) begin
					cmd.div_start = 1'b1;
					cmd.div_src   = DIV_WALK;
					state_d       = S_DIV_WALK;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DIV_WALK: begin
				if (stat.div_done) begin
					cmd.walk_init = 1'b1;
					state_d       = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				if (stat.walk_done) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end
endmodule

// ===== rtl/core/pdds_dp.sv =====
// Datapath: per-destination FIFO pointers, target list, remainder unit,
// result register. Depends on pdds_pkg and pdds_ram.
module pdds_dp #(
	parameter int QUEUE_DEPTH = pdds_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  pdds_pkg::in_item_t                   item,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pdds_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pdds_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                 result_valid,
	input  logic                                 result_ready,
	output pdds_pkg::out_item_t                  result,
	input  pdds_pkg::ctl_cmd_t                   cmd,
	output pdds_pkg::ctl_stat_t                  stat
);
	import pdds_pkg::*;

	localparam int PTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int RAM_D    = MAX_NODES * (2 ** PTR_W);
	localparam int RAM_AW   = $clog2(RAM_D);
	localparam int DSTEP_W  = $clog2(TIME_W + 1);

	logic [CNT_W-1:0]  nodes_cfg_q;
	logic [NODE_W-1:0] own_id_q;

	logic [PTR_W-1:0]  head_q [MAX_NODES];
	logic [PTR_W-1:0]  tail_q [MAX_NODES];
	logic [FILL_W-1:0] fill_q [MAX_NODES];
	logic [MAX_NODES-1:0] marked_q;
	logic [NODE_W-1:0] list_q [MAX_NODES];
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  served_q;
	logic [31:0]       sent_count_q;

	logic [NODE_W-1:0] dest_q;
	logic [PKT_W-1:0]  pkt_in_q;
	logic [PKT_W-1:0]  pkt_q;
	logic [NODE_W-1:0] slot_q;
	logic [NODE_W-1:0] tgt_q;
	logic              have_q;
	logic              popped_q;
	logic              drop_q;
	logic [NODE_W-1:0] walk_n_q;
	logic [NODE_W-1:0] walk_i_q;

	// remainder unit: one dividend bit per cycle
	logic [NODE_W-1:0]  rem_q;
	logic [TIME_W-1:0]  dvd_q;
	logic [CNT_W-1:0]   dvs_q;
	logic [DSTEP_W-1:0] dcnt_q;
	logic [CNT_W-1:0]   rem_try;
	logic [CNT_W-1:0]   rem_next;

	logic [CNT_W-1:0]  nc;
	logic [CNT_W-1:0]  nc_m1;
	logic              pop_ok;
	logic              enq_full;
	logic [RAM_AW-1:0] ram_waddr;
	logic [RAM_AW-1:0] ram_raddr;
	logic [PKT_W-1:0]  ram_rdata;
	logic              ram_we;
	logic              ram_re;
	logic [CNT_W-1:0]  walk_n_inc;

	always_comb begin
		if (nodes_cfg_q < CNT_W'(2)) begin
			nc = CNT_W'(2);
		end else if (nodes_cfg_q > CNT_W'(MAX_NODES)) begin
			nc = CNT_W'(MAX_NODES);
		end else begin
			nc = nodes_cfg_q;
		end
	end
	assign nc_m1 = nc - CNT_W'(1);

	assign rem_try  = {rem_q, dvd_q[TIME_W-1]};
	assign rem_next = (rem_try >= dvs_q) ? (rem_try - dvs_q) : rem_try;

	assign enq_full  = (fill_q[dest_q] == FILL_W'(QUEUE_DEPTH));
	assign pop_ok    = have_q && (fill_q[tgt_q] != '0);
	assign ram_we    = cmd.enq && !enq_full;
	assign ram_re    = cmd.pop && pop_ok;
	assign ram_waddr = {dest_q, tail_q[dest_q]};
	assign ram_raddr = {tgt_q, head_q[tgt_q]};
	assign walk_n_inc = {1'b0, walk_n_q} + CNT_W'(1);

	assign cfg_ready = 1'b1;

	assign stat.item_tick       = item.mode;
	assign stat.div_done        = (dcnt_q == '0);
	assign stat.served_lt_total = (served_q < total_q);
	assign stat.total_nz        = (total_q != '0);
	assign stat.last_slot       = ({1'b0, slot_q} == nc - CNT_W'(2));
	assign stat.walk_done       = ({1'b0, walk_i_q} == nc_m1);
	assign stat.out_free        = !result_valid || result_ready;

	pdds_ram #(
		.WIDTH(PKT_W),
		.DEPTH(RAM_D)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(pkt_in_q),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nodes_cfg_q  <= NODES_RST;
			own_id_q     <= '0;
			for (int i = 0; i < MAX_NODES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				fill_q[i] <= '0;
			end
			marked_q     <= '0;
			total_q      <= '0;
			served_q     <= '0;
			sent_count_q <= '0;
			have_q       <= 1'b0;
			popped_q     <= 1'b0;
			drop_q       <= 1'b0;
			dcnt_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_NODES:  nodes_cfg_q <= cfg_data;
					CFG_OWN_ID: own_id_q    <= cfg_data[NODE_W-1:0];
					default: ;
				endcase
			end

			if (cmd.load) begin
				have_q   <= 1'b0;
				popped_q <= 1'b0;
				drop_q   <= 1'b0;
			end

			if (cmd.div_start) begin
				case (cmd.div_src)
					DIV_SLOT: dcnt_q <= DSTEP_W'(TIME_W);
					default:  dcnt_q <= DSTEP_W'(SHORT_DIV_STEPS);
				endcase
			end else if (dcnt_q != '0) begin
				dcnt_q <= dcnt_q - DSTEP_W'(1);
			end

			if (cmd.enq) begin
				drop_q <= enq_full;
				if (!enq_full) begin
					tail_q[dest_q] <= (tail_q[dest_q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
						: tail_q[dest_q] + PTR_W'(1);
					fill_q[dest_q] <= fill_q[dest_q] + FILL_W'(1);
				end
				if (!marked_q[dest_q] && (total_q < nc_m1)) begin
					marked_q[dest_q] <= 1'b1;
					total_q          <= total_q + CNT_W'(1);
				end
			end

			if (cmd.pick_list) begin
				have_q   <= 1'b1;
				served_q <= served_q + CNT_W'(1);
			end
			if (cmd.pick_slot) begin
				have_q <= 1'b1;
			end

			if (ram_re) begin
				popped_q       <= 1'b1;
				head_q[tgt_q]  <= (head_q[tgt_q] == PTR_W'(QUEUE_DEPTH - 1)) ? '0
					: head_q[tgt_q] + PTR_W'(1);
				fill_q[tgt_q]  <= fill_q[tgt_q] - FILL_W'(1);
				sent_count_q   <= sent_count_q + 32'd1;
				if (fill_q[tgt_q] == FILL_W'(1)) begin
					marked_q[tgt_q] <= 1'b0;
				end
			end

			if (cmd.walk_init) begin
				total_q  <= '0;
				served_q <= '0;
			end
			if (cmd.walk_step && marked_q[walk_n_q]) begin
				total_q <= total_q + CNT_W'(1);
			end

			if (cmd.emit) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	// payload and working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dest_q   <= item.destination;
			pkt_in_q <= item.packet_data;
		end

		if (cmd.div_start) begin
			rem_q <= '0;
			case (cmd.div_src)
				DIV_SLOT: begin
					dvd_q <= item.tick_time;
					dvs_q <= nc_m1;
				end
				DIV_PICK: begin
					dvd_q <= {1'b0, slot_q, (TIME_W - CNT_W)'(0)};
					dvs_q <= total_q;
				end
				default: begin
					dvd_q <= {({1'b0, own_id_q} + CNT_W'(1)), (TIME_W - CNT_W)'(0)};
					dvs_q <= nc;
				end
			endcase
		end else if (dcnt_q != '0) begin
			rem_q <= rem_next[NODE_W-1:0];
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
		end

		if (cmd.take_slot) begin
			slot_q <= rem_q;
		end
		if (cmd.pick_list) begin
			tgt_q <= list_q[served_q[NODE_W-1:0]];
		end
		if (cmd.pick_slot) begin
			tgt_q <= list_q[rem_q];
		end

		if (cmd.enq && !marked_q[dest_q] && (total_q < nc_m1)) begin
			list_q[total_q[NODE_W-1:0]] <= dest_q;
		end

		if (cmd.capture) begin
			pkt_q <= ram_rdata;
		end

		if (cmd.walk_init) begin
			walk_n_q <= rem_q;
			walk_i_q <= NODE_W'(1);
		end else if (cmd.walk_step) begin
			if (marked_q[walk_n_q]) begin
				list_q[total_q[NODE_W-1:0]] <= walk_n_q;
			end
			walk_n_q <= (walk_n_inc == nc) ? '0 : walk_n_inc[NODE_W-1:0];
			walk_i_q <= walk_i_q + NODE_W'(1);
		end

		if (cmd.emit) begin
			result.sent_valid       <= popped_q;
			result.sent_destination <= popped_q ? tgt_q : '0;
			result.sent_data        <= popped_q ? pkt_q : '0;
			result.dropped          <= drop_q;
			result.total_sent       <= sent_count_q;
		end
	end
endmodule

// ===== rtl/core/per_destination_drain_scheduler_top.sv =====
// Top level of the per-destination drain scheduler.
// Depends on pdds_pkg, pdds_ctrl, pdds_dp (and pdds_ram through pdds_dp).
//
// Usage:
//   item channel (item_valid/item_ready/item) takes one request at a time:
//   mode 0 enqueues packet_data for destination, mode 1 is a time tick.
//   result channel (result_valid/result_ready/result) returns exactly one
//   result per request, in order. cfg channel writes the node total
//   (index 0) or own_id (index 1); cfg_ready is always high.
// Sequence:
//   enqueue: packet_data goes to its destination FIFO, or is dropped when
//   that FIFO is full; the result then goes to the output register.
//   tick: the slot is the tick time modulo nodes-1; the target is the next
//   unserved list entry, else the entry at the slot modulo the list length;
//   one packet is popped from it if any; on the last slot of a period the
//   list is rebuilt from node (own_id+1) modulo nodes, nodes being the node
//   total saturated to 2..16. The remainder unit retires one dividend bit
//   per cycle, and the list rebuild visits one node per cycle.
// Reset clears all FIFOs, marks, the list length and the sent counter;
// the node total returns to 16 and own_id to 0.
// A finished result waits in the output register while result_ready is low;
// a new request is taken meanwhile, and its result is held back until the
// register frees.
module per_destination_drain_scheduler_top #(
	parameter int QUEUE_DEPTH = pdds_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  pdds_pkg::in_item_t              item,
	output logic                            result_valid,
	input  logic                            result_ready,
	output pdds_pkg::out_item_t             result,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pdds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdds_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pdds_pkg::*;

	ctl_cmd_t  cmd;
	ctl_stat_t stat;

	pdds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pdds_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result),
		.cmd         (cmd),
		.stat        (stat)
	);

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("result register overwritten while pending");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> stat.div_done)
		else $error("remainder unit restarted while busy");

	a_drop_xor_sent: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.dropped && result.sent_valid))
		else $error("result flags both drop and send");

	a_accept_no_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready) |=> !cmd.emit)
		else $error("result emitted in cycle after accept");
endmodule

// ===== tb/sv/pdds_scoreboard.sv =====
// Checker for the per-destination drain scheduler: watches the request,
// result and register channels, predicts each result and compares it.
// Depends on pdds_pkg.
module pdds_scoreboard (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	input  logic                            item_ready,
	input  pdds_pkg::in_item_t              item,
	input  logic                            result_valid,
	input  logic                            result_ready,
	input  pdds_pkg::out_item_t             result,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [pdds_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pdds_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                              errors,
	output int                              pending
);
	import pdds_pkg::*;

	localparam int DEPTH = QUEUE_DEPTH_DEF;

	logic [PKT_W-1:0]  pkt_mem [MAX_NODES][DEPTH];
	logic [3:0]        rd_ptr [MAX_NODES];
	logic [3:0]        wr_ptr [MAX_NODES];
	int unsigned       occupancy [MAX_NODES];
	bit                marked [MAX_NODES];
	logic [NODE_W-1:0] dest_list [MAX_NODES];
	int unsigned       list_len;
	int unsigned       served;
	logic [31:0]       sent_total;
	logic [4:0]        nodes_reg;
	logic [3:0]        id_reg;
	out_item_t         expected_results [$];

	function automatic out_item_t schedule_request(in_item_t req);
		out_item_t r;
		int unsigned nc, slot, tgt, d, n;
		bit have;
		r = '0;
		nc = 32'(nodes_reg);
		if (nc < 2) nc = 2;
		if (nc > MAX_NODES) nc = MAX_NODES;
		if (req.mode == 1'b0) begin
			d = 32'(req.destination);
			if (occupancy[d] >= DEPTH) begin
				r.dropped = 1'b1;
			end else begin
				pkt_mem[d][wr_ptr[d]] = req.packet_data;
				wr_ptr[d] = wr_ptr[d] + 4'd1;
				occupancy[d]++;
			end
			if (!marked[d] && list_len < nc - 1) begin
				marked[d] = 1'b1;
				dest_list[list_len] = NODE_W'(d);
				list_len++;
			end
		end else begin
			slot = req.tick_time % (nc - 1);
			have = 1'b0;
			tgt = 0;
			if (served < list_len) begin
				tgt = 32'(dest_list[served]);
				served++;
				have = 1'b1;
			end else if (list_len > 0) begin
				tgt = 32'(dest_list[slot % list_len]);
				have = 1'b1;
			end
			if (have && occupancy[tgt] > 0) begin
				r.sent_data = pkt_mem[tgt][rd_ptr[tgt]];
				rd_ptr[tgt] = rd_ptr[tgt] + 4'd1;
				occupancy[tgt]--;
				sent_total++;
				r.sent_valid = 1'b1;
				r.sent_destination = NODE_W'(tgt);
				if (occupancy[tgt] == 0) marked[tgt] = 1'b0;
			end
			if (slot == nc - 2) begin
				list_len = 0;
				served = 0;
				for (int i = 1; i < nc; i++) begin
					n = (id_reg + i) % nc;
					if (marked[n]) begin
						dest_list[list_len] = NODE_W'(n);
						list_len++;
					end
				end
			end
		end
		r.total_sent = sent_total;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAX_NODES; i++) begin
				rd_ptr[i] = '0;
				wr_ptr[i] = '0;
				occupancy[i] = 0;
				marked[i] = 1'b0;
				dest_list[i] = '0;
			end
			list_len = 0;
			served = 0;
			sent_total = '0;
			nodes_reg = NODES_RST;
			id_reg = '0;
			expected_results.delete();
			errors = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_NODES) nodes_reg = cfg_data;
				else if (cfg_index == CFG_OWN_ID) id_reg = cfg_data[3:0];
			end
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result %p", $time, result);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (result.sent_valid !== want.sent_valid ||
					    result.sent_destination !== want.sent_destination ||
					    result.sent_data !== want.sent_data ||
					    result.dropped !== want.dropped ||
					    result.total_sent !== want.total_sent) begin
						$display("%0t: mismatch expected %p actual %p", $time, want,
							result);
						errors++;
					end
				end
			end
			if (item_valid && item_ready)
				expected_results.push_back(schedule_request(item));
		end
		pending = expected_results.size();
	end
endmodule

// ===== tb/sv/per_destination_drain_scheduler_top_tb.sv =====
// Stimulus and verdict for the per-destination drain scheduler.
// Depends on pdds_pkg, per_destination_drain_scheduler_top and pdds_scoreboard.
module per_destination_drain_scheduler_top_tb;
	import pdds_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  item_valid;
	logic                  item_ready;
	in_item_t              item;
	logic                  result_valid;
	logic                  result_ready;
	out_item_t             result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    errors;
	int                    pending;
	bit                    sink_idle_on;
	bit                    hold_sink;

	per_destination_drain_scheduler_top dut (.*);
	pdds_scoreboard checker_i (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// result side: random stalls, optional long hold-off
	initial begin
		int stall;
		result_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_sink) begin
				result_ready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 11);
				result_ready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	// valid stays high after an accept unless a gap or a drain follows
	task automatic send_request(input bit mode, input logic [3:0] dest,
		input logic [31:0] data, input logic [31:0] now, input bit gaps);
		if (gaps && $urandom_range(0, 4) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item.mode <= mode;
		item.destination <= dest;
		item.packet_data <= data;
		item.tick_time <= now;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	task automatic drain_and_wait();
		item_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_phase(input int count, input bit gaps);
		logic [31:0] now;
		now = $urandom;
		for (int i = 0; i < count; i++) begin
			now = now + 1;
			if ($urandom_range(0, 2) == 0)
				send_request(1'b1, 4'($urandom), $urandom, now, gaps);
			else if ($urandom_range(0, 9) == 0)
				send_request(1'b1, 4'($urandom), $urandom, $urandom, gaps);
			else
				send_request(1'b0, $urandom_range(0, 5) == 0 ? 4'($urandom) :
					4'($urandom_range(0, 4)), $urandom, $urandom, gaps);
		end
	endtask

	initial begin
		int stretch;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sink_idle_on = 1'b0;
		hold_sink = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, empty tick, full FIFO, high destination
		send_request(1'b1, 4'd0, 32'd0, 32'd0, 1'b0);
		send_request(1'b0, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0);
		send_request(1'b0, 4'd0, 32'h0, 32'h0, 1'b0);
		for (int i = 0; i < 17; i++)
			send_request(1'b0, 4'd3, $urandom, 32'd0, 1'b0);
		send_request(1'b1, 4'd0, 32'd0, 32'hFFFFFFFF, 1'b0);
		send_request(1'b1, 4'd0, 32'd0, 32'd14, 1'b0);
		send_request(1'b1, 4'd0, 32'd0, 32'd5, 1'b0);
		drain_and_wait();

		// small network, own id above node total
		write_reg(CFG_NODES, 5'd2);
		write_reg(CFG_OWN_ID, 5'd15);
		sink_idle_on = 1'b1;
		random_phase(80, 1'b1);
		drain_and_wait();

		// out-of-range node totals saturate
		write_reg(CFG_NODES, 5'd31);
		write_reg(CFG_OWN_ID, 5'd7);
		random_phase(60, 1'b1);
		drain_and_wait();
		write_reg(CFG_NODES, 5'd0);
		random_phase(30, 1'b1);
		drain_and_wait();

		write_reg(CFG_NODES, 5'd5);
		write_reg(CFG_OWN_ID, 5'd2);
		// long receiver hold-off while requests keep coming
		fork
			begin
				hold_sink = 1'b1;
				stretch = 0;
				while (stretch < 300) begin
					@(posedge clk);
					stretch++;
				end
				hold_sink = 1'b0;
			end
			random_phase(60, 1'b0);
		join
		drain_and_wait();

		write_reg(CFG_NODES, 5'd16);
		write_reg(CFG_OWN_ID, 5'd0);
		random_phase(80, 1'b1);
		// no idling in the last part
		sink_idle_on = 1'b0;
		random_phase(60, 1'b0);
		drain_and_wait();

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#12000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/pdds_pkg.sv
rtl/core/pdds_ram.sv
rtl/core/pdds_ctrl.sv
rtl/core/pdds_dp.sv
rtl/core/per_destination_drain_scheduler_top.sv
tb/sv/pdds_scoreboard.sv
tb/sv/per_destination_drain_scheduler_top_tb.sv
